@@ design/brc_pkg.sv @@
// Shared types and constants for the bitmap run counter.
// Used by brc_ctrl, bitmap_run_counter_top, brc_checker and the testbench top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

  // Fixed field widths of the block's ports.
  localparam int POS_W = 10;
  localparam int LEN_W = 11;
  localparam int RUN_W = 10;

  // Largest run count; the counter saturates here.
  localparam logic [RUN_W-1:0] RUN_LIMIT = {RUN_W{1'b1}};

  // Operation codes of an input beat.
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_SET   = 1'b1;

  // One input beat.
  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] position;
  } brc_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_UPDATE
  } brc_state_t;

endpackage

`default_nettype wire

@@ design/brc_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/brc_ctrl.sv @@
// Sequencer for the bitmap run counter: clearing pass, neighbor reads,
// bit write-back and the run count register. Depends on brc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brc_ctrl #(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire brc_pkg::brc_item_t               item,
  input  wire logic [brc_pkg::LEN_W-1:0]        eff_len,
  output logic                                  busy,
  output logic                                  out_valid,
  output logic [brc_pkg::RUN_W-1:0]             out_run_total,
  output logic                                  ram_we,
  output logic [$clog2(MAX_LENGTH)-1:0]         ram_waddr,
  output logic                                  ram_wdata,
  output logic                                  ram_re,
  output logic [$clog2(MAX_LENGTH)-1:0]         ram_raddr,
  input  wire logic                             ram_rdata
);

  import brc_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);

  brc_state_t       state_r, state_nxt;
  logic [AW-1:0]    clr_ptr_r, clr_ptr_nxt;
  logic [POS_W-1:0] pos_r;
  logic             center_r;
  logic             left_r;
  logic [RUN_W-1:0] run_count_r, run_count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [RUN_W-1:0] out_run_total_r;

  logic             accept;
  logic             set_hit;
  logic [AW-1:0]    pos_a;
  logic             left_ok;
  logic             right_ok;
  logic             left_bit;
  logic             right_bit;

  // Beat acceptance and range check of a set position.
  assign accept  = start && (state_r == ST_IDLE);
  assign set_hit = accept && (item.operation == OP_SET)
                   && ({1'b0, item.position} < eff_len);

  // Neighbors count only when they lie inside the map.
  assign pos_a     = AW'(pos_r);
  assign left_ok   = (pos_r != '0);
  assign right_ok  = (({1'b0, pos_r} + LEN_W'(1)) < eff_len);
  assign left_bit  = left_r && left_ok;
  assign right_bit = ram_rdata && right_ok;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_ptr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (set_hit) state_nxt = ST_RD_LEFT;
      end
      ST_RD_LEFT:  state_nxt = ST_RD_RIGHT;
      ST_RD_RIGHT: state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_ptr_r;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = pos_a;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_re    = set_hit;
        ram_raddr = AW'(item.position);
      end
      ST_RD_LEFT: begin
        ram_re    = 1'b1;
        ram_raddr = pos_a - AW'(1);
      end
      ST_RD_RIGHT: begin
        ram_re    = 1'b1;
        ram_raddr = pos_a + AW'(1);
      end
      ST_UPDATE: begin
        ram_we    = !center_r;
        ram_waddr = pos_a;
        ram_wdata = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Clearing pointer and run count update.
  always_comb begin
    clr_ptr_nxt   = clr_ptr_r;
    run_count_nxt = run_count_r;
    if (state_r == ST_CLEAR) begin
      clr_ptr_nxt = clr_ptr_r + AW'(1);
    end
    if ((state_r == ST_UPDATE) && !center_r) begin
      if (!left_bit && !right_bit) begin
        if (run_count_r != RUN_LIMIT) run_count_nxt = run_count_r + RUN_W'(1);
      end else if (left_bit && right_bit) begin
        if (run_count_r != '0) run_count_nxt = run_count_r - RUN_W'(1);
      end
    end
  end

  assign out_valid_nxt = accept && (item.operation == OP_QUERY);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_ptr_r   <= '0;
      run_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      run_count_r <= run_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (set_hit) pos_r <= item.position;
    if (state_r == ST_RD_LEFT) center_r <= ram_rdata;
    if (state_r == ST_RD_RIGHT) left_r <= ram_rdata;
    if (out_valid_nxt) out_run_total_r <= run_count_r;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_run_total = out_run_total_r;

endmodule

`default_nettype wire

@@ design/bitmap_run_counter_top.sv @@
// Top level of the bitmap run counter: configuration register, length clamp,
// sequencer and bitmap memory. Depends on brc_pkg, brc_ctrl and brc_ram.
//
// Usage:
//   Input beats are taken at a clock edge where start is high and busy is
//   low. in_operation selects a query (returns the run count) or a set of
//   the bit at in_position.
//   A query produces one result: out_valid pulses for one cycle, the cycle
//   after the beat, with out_run_total. The receiver cannot stall; each
//   result is valid for exactly that one cycle. Queries may follow each
//   other every cycle.
//   A set produces no result. It holds busy through ST_RD_LEFT, ST_RD_RIGHT
//   and ST_UPDATE after the beat, set by the single read port of the bitmap
//   memory: the bit itself and its two neighbors are read one per cycle,
//   then the bit is written back. A set outside the map length does not
//   raise busy.
//   The map length is written through cfg_valid/cfg_ready/cfg_map_length,
//   which is always ready; write it only while the block is idle.
//   After reset the bitmap is cleared by a pass over the memory, one entry
//   per cycle over all MAX_LENGTH entries, with busy held high. The run count resets
//   to zero and the map length to 1024.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_run_counter_top #(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_operation,
  input  wire logic [brc_pkg::POS_W-1:0]   in_position,
  output logic                             out_valid,
  output logic [brc_pkg::RUN_W-1:0]        out_run_total,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [brc_pkg::LEN_W-1:0]   cfg_map_length
);

  import brc_pkg::*;

  localparam int AW      = $clog2(MAX_LENGTH);
  localparam int LEN_CAP = (MAX_LENGTH > 2047) ? 2047 : MAX_LENGTH;
  localparam logic [LEN_W-1:0] LEN_CAP_V   = LEN_W'(LEN_CAP);
  localparam logic [LEN_W-1:0] LEN_RESET_V = LEN_W'(1024);

  logic [LEN_W-1:0] map_length_r;
  logic [LEN_W-1:0] eff_len;
  brc_item_t        item;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic             ram_rdata;

  // Configuration register; a write beat is taken whenever valid is high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_length_r <= LEN_RESET_V;
    end else if (cfg_valid && cfg_ready) begin
      map_length_r <= cfg_map_length;
    end
  end

  // Usable length is the configured length clamped to the memory size.
  assign eff_len = (map_length_r > LEN_CAP_V) ? LEN_CAP_V : map_length_r;

  assign item.operation = in_operation;
  assign item.position  = in_position;

  // Sequencer and run count.
  brc_ctrl #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .item          (item),
    .eff_len       (eff_len),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_run_total (out_run_total),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // Bitmap storage, one bit per position.
  brc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LENGTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ bench/brc_checker.sv @@
// Scoreboard for the bitmap run counter: watches the input, result and
// length-register channels, keeps its own bitmap and run tally, and checks
// every run total. Depends on brc_pkg.
`timescale 1ns / 1ps

module brc_checker #(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic                        in_operation,
  input  wire logic [brc_pkg::POS_W-1:0]   in_position,
  input  wire logic                        out_valid,
  input  wire logic [brc_pkg::RUN_W-1:0]   out_run_total,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [brc_pkg::LEN_W-1:0]   cfg_map_length,
  output int                               fail_count,
  output int                               pending,
  output int                               totals_checked,
  output int                               runs_opened,
  output int                               runs_merged
);
  import brc_pkg::*;

  // Shadow copy of the block's state.
  logic [MAX_LENGTH-1:0] lit_map;
  logic [RUN_W-1:0]      run_tally;
  logic [LEN_W-1:0]      map_span;

  // Run totals owed by queries that have been accepted but not yet returned.
  logic [RUN_W-1:0]      totals_due[$];

  int fails;
  int n_checked;
  int n_opened;
  int n_merged;

  // Only the first ten mismatches are printed; the rest are counted.
  task automatic note_failure(input string what);
    fails++;
    if (fails <= 10) begin
      $display("[%0t] Mismatch: %s", $realtime, what);
    end
  endtask

  // Marks one position and adjusts the run tally from its in-map neighbors.
  function automatic void mark_position(input logic [POS_W-1:0] pos);
    int   lim;
    logic left_on;
    logic right_on;
    lim = (int'(map_span) > MAX_LENGTH) ? MAX_LENGTH : int'(map_span);
    if (int'(pos) >= lim || lit_map[pos]) begin
      return;
    end
    left_on  = (pos > 0) && lit_map[int'(pos) - 1];
    right_on = (int'(pos) + 1 < lim) && lit_map[int'(pos) + 1];
    if (!left_on && !right_on) begin
      if (run_tally != RUN_LIMIT) begin
        run_tally = run_tally + 1'b1;
      end
      n_opened++;
    end else if (left_on && right_on) begin
      if (run_tally != '0) begin
        run_tally = run_tally - 1'b1;
      end
      n_merged++;
    end
    lit_map[pos] = 1'b1;
  endfunction

  // Results are checked before the beat of the same edge is predicted; a
  // result can never stem from a beat taken at the same edge.
  always @(posedge clk) begin
    logic [RUN_W-1:0] want;
    if (!rst_n) begin
      lit_map   = '0;
      run_tally = '0;
      map_span  = LEN_W'(1024);
      totals_due.delete();
    end else begin
      if (out_valid) begin
        n_checked++;
        if (totals_due.size() == 0) begin
          note_failure($sformatf("run total %0d with no query outstanding", out_run_total));
        end else begin
          want = totals_due.pop_front();
          if (out_run_total !== want) begin
            note_failure($sformatf("run total expected %0d, got %0d", want, out_run_total));
          end
        end
      end
      if (start && !busy) begin
        if (in_operation == OP_QUERY) begin
          totals_due.push_back(run_tally);
        end else begin
          mark_position(in_position);
        end
      end
      if (cfg_valid && cfg_ready) begin
        map_span = cfg_map_length;
      end
    end
    fail_count     <= fails;
    pending        <= totals_due.size();
    totals_checked <= n_checked;
    runs_opened    <= n_opened;
    runs_merged    <= n_merged;
  end

endmodule

@@ bench/bitmap_run_counter_top_tb.sv @@
// Testbench top for the bitmap run counter: clock, reset, stimulus on the
// input and length-register channels, watchdog and verdict. Depends on
// brc_pkg, bitmap_run_counter_top and brc_checker.
`timescale 1ns / 1ps

module bitmap_run_counter_top_tb;
  import brc_pkg::*;

  localparam int MAX_LENGTH     = 1024;
  localparam int WATCHDOG_LIMIT = 4000;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             start          = 1'b0;
  logic             in_operation   = OP_QUERY;
  logic [POS_W-1:0] in_position    = '0;
  logic             cfg_valid      = 1'b0;
  logic [LEN_W-1:0] cfg_map_length = '0;
  logic             busy;
  logic             out_valid;
  logic [RUN_W-1:0] out_run_total;
  logic             cfg_ready;

  int fail_count;
  int pending;
  int totals_checked;
  int runs_opened;
  int runs_merged;

  int   quiet_cycles = 0;
  int   beats_sent   = 0;
  int   lengths_set  = 0;
  bit   gaps_on      = 1'b1;
  int   last_pos     = 0;
  int   phase_len[8] = '{3, 24, 96, 2047, 0, 700, 1024, 0};

  always #6 clk = ~clk;

  bitmap_run_counter_top #(
    .MAX_LENGTH(MAX_LENGTH)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_run_total (out_run_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_map_length(cfg_map_length)
  );

  brc_checker #(
    .MAX_LENGTH(MAX_LENGTH)
  ) i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_run_total (out_run_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_map_length(cfg_map_length),
    .fail_count    (fail_count),
    .pending       (pending),
    .totals_checked(totals_checked),
    .runs_opened   (runs_opened),
    .runs_merged   (runs_merged)
  );

  // Watchdog: any cycle without a beat on some channel counts toward the limit.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  // Offers one beat and holds it until the block takes it.
  task automatic send_beat(input logic op, input int pos);
    int gap;
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= POS_W'(pos);
    do @(posedge clk); while (busy);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes the map length once the block has drained and settled.
  task automatic write_length(input int len);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6 + $urandom_range(4)) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_map_length <= LEN_W'(len);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lengths_set++;
  endtask

  // One random phase: queries, sets in the map (often next to the last set
  // so runs grow and merge), and stray sets anywhere.
  task automatic run_phase(input int n_items, input int span);
    int lim;
    int r;
    int pos;
    lim = (span > MAX_LENGTH) ? MAX_LENGTH : span;
    if (lim < 1) begin
      lim = 1;
    end
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(19) == 0) begin
        gaps_on = !gaps_on;
      end
      r = $urandom_range(99);
      if (r < 35) begin
        send_beat(OP_QUERY, $urandom_range(MAX_LENGTH - 1));
      end else if (r < 88) begin
        if ($urandom_range(99) < 35) begin
          pos = last_pos + $urandom_range(4) - 2;
        end else begin
          pos = $urandom_range(lim - 1);
        end
        if (pos < 0) begin
          pos = 0;
        end
        if (pos > lim - 1) begin
          pos = lim - 1;
        end
        last_pos = pos;
        send_beat(OP_SET, pos);
      end else begin
        send_beat(OP_SET, $urandom_range(MAX_LENGTH - 1));
      end
    end
  endtask

  initial begin
    int span;

    // Reset, then let the clearing pass over the bitmap finish.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed part at the reset length: runs at the top edge, a merge,
    // a set of a bit that is already set, and growth of a run.
    send_beat(OP_QUERY, MAX_LENGTH - 1);
    send_beat(OP_SET, 1023);
    send_beat(OP_SET, 1021);
    send_beat(OP_QUERY, 0);
    send_beat(OP_SET, 1022);
    send_beat(OP_SET, 1022);
    send_beat(OP_QUERY, 0);
    send_beat(OP_SET, 1019);
    send_beat(OP_SET, 1018);
    send_beat(OP_QUERY, 0);

    // A map of one position: the sole bit forms a run; the next is outside.
    write_length(1);
    send_beat(OP_SET, 0);
    send_beat(OP_SET, 1);
    send_beat(OP_QUERY, 0);

    // A length of zero leaves no usable position.
    write_length(0);
    send_beat(OP_SET, 7);
    send_beat(OP_QUERY, 0);

    // Lengths above the maximum are clamped; this set joins two runs.
    write_length(2047);
    send_beat(OP_SET, 1020);
    send_beat(OP_QUERY, 0);
    write_length(1025);
    send_beat(OP_SET, 512);
    send_beat(OP_SET, 513);
    send_beat(OP_QUERY, 0);

    // A set bit beyond a shortened map is not a neighbor.
    write_length(1018);
    send_beat(OP_SET, 1017);
    send_beat(OP_QUERY, 0);

    // Random phases, from tiny maps that fill up to the full range.
    for (int p = 0; p < 8; p++) begin
      span = (phase_len[p] == 0) ? $urandom_range(MAX_LENGTH, 1) : phase_len[p];
      write_length(span);
      gaps_on  = (p % 3 != 1);
      last_pos = $urandom_range(((span > MAX_LENGTH) ? MAX_LENGTH : span) - 1);
      run_phase(80, span);
    end

    // Drain and let the last set settle.
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d input beats over %0d map lengths, %0d run totals checked,",
             beats_sent, lengths_set, totals_checked);
    $display("with %0d runs opened and %0d runs merged.", runs_opened, runs_merged);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/brc_pkg.sv
design/brc_ram.sv
design/brc_ctrl.sv
design/bitmap_run_counter_top.sv
bench/brc_checker.sv
bench/bitmap_run_counter_top_tb.sv
